/* design/ecc_pkg.sv */
// Shared types, constants and the month-start table of the epoch calendar converter.
`default_nettype none

package ecc_pkg;

    // Request direction codes
    localparam logic REQ_TO_EPOCH = 1'b0;
    localparam logic REQ_TO_DATE  = 1'b1;

    // Epoch seconds at 2000-01-01 00:00:00 and at 2100-01-01 00:00:00
    localparam logic [31:0] EPOCH_Y2K   = 32'd946684800;
    localparam logic [31:0] EPOCH_Y2100 = 32'd4102444800;

    // Days in one four-year cycle, first year leap
    localparam logic [10:0] CYCLE_DAYS = 11'd1461;

    // Reciprocal constants: floor(x / d) = (x * M) >> S over the stated input range
    localparam logic [31:0] RECIP_60   = 32'h8888_8889;  // x < 2^32, shift 37
    localparam int          SHIFT_60   = 37;
    localparam logic [20:0] RECIP_24   = 21'd1398102;    // x < 2^20, shift 25
    localparam int          SHIFT_24   = 25;
    localparam logic [21:0] RECIP_1461 = 22'd2939745;    // x < 2^16, shift 32
    localparam int          SHIFT_1461 = 32;

    // Cumulative day offset of each month start within a four-year cycle
    localparam logic [10:0] MONTH_START [4][12] = '{
        '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
          11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
        '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
          11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
        '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

    // Request beat
    typedef struct packed {
        logic        req_type;
        logic [31:0] epoch_in;
        logic [6:0]  year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } ecc_in_t;

    // Result beat
    typedef struct packed {
        logic [31:0] epoch_out;
        logic [6:0]  year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic        range_error;
    } ecc_out_t;

    // Working contents of one pipeline stage
    // acc and quo hold the running sum (to epoch) or the dividend and quotient (to date);
    // hr, mi, se carry the time inputs (to epoch) or collect the time results (to date).
    typedef struct packed {
        logic        req;
        logic        err;
        logic [31:0] acc;
        logic [31:0] quo;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [5:0]  se;
    } ecc_stage_t;

endpackage

`default_nettype wire

/* design/ecc_front.sv */
// First stage: range check, epoch offset and day count of the calendar date.
`default_nettype none

module ecc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire ecc_pkg::ecc_in_t   up_data,
    output logic                    down_valid,
    input  wire logic               down_ready,
    output ecc_pkg::ecc_stage_t     down_data
);
    import ecc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    ecc_stage_t stage_reg;
    ecc_stage_t stage_next;

    // Take a new beat when empty or when the next stage drains
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Build the stage contents for either direction
    always_comb
    begin
        logic [3:0]  midx;
        logic [31:0] tday;

        case (up_data.month_in) inside
            4'd0:          midx = 4'd0;
            [4'd1:4'd12]:  midx = up_data.month_in - 4'd1;
            default:       midx = 4'd11;
        endcase

        // Days since 2000-01-01, wrapping like the epoch sum
        tday = 32'({27'd0, up_data.year_in[6:2]} * {21'd0, CYCLE_DAYS})
             + {21'd0, MONTH_START[up_data.year_in[1:0]][midx]}
             + {27'd0, up_data.day_in} - 32'd1;

        stage_next.req = up_data.req_type;
        stage_next.err = (up_data.req_type == REQ_TO_DATE)
                      && ((up_data.epoch_in < EPOCH_Y2K) || (up_data.epoch_in >= EPOCH_Y2100));
        stage_next.acc = (up_data.req_type == REQ_TO_DATE) ? (up_data.epoch_in - EPOCH_Y2K)
                                                            : tday;
        stage_next.quo = '0;
        stage_next.hr  = up_data.hour_in;
        stage_next.mi  = up_data.minute_in;
        stage_next.se  = up_data.second_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            stage_reg <= stage_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = stage_reg;

endmodule

`default_nettype wire

/* design/ecc_arith.sv */
// Five arithmetic stages: seconds, minutes, hours and four-year cycles by reciprocal
// multiplication, or the scaled epoch sum in the other direction.
`default_nettype none

module ecc_arith (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire ecc_pkg::ecc_stage_t up_data,
    output logic                     down_valid,
    input  wire logic                down_ready,
    output ecc_pkg::ecc_stage_t      down_data
);
    import ecc_pkg::*;

    logic [4:0] valid_reg;
    logic [4:0] valid_next;
    logic [4:0] rdy;

    ecc_stage_t s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    ecc_stage_t s2_next, s3_next, s4_next, s5_next, s6_next;

    // Each stage loads when empty or when its successor moves on
    always_comb
    begin
        rdy[4] = !valid_reg[4] || down_ready;
        rdy[3] = !valid_reg[3] || rdy[4];
        rdy[2] = !valid_reg[2] || rdy[3];
        rdy[1] = !valid_reg[1] || rdy[2];
        rdy[0] = !valid_reg[0] || rdy[1];

        valid_next[0] = rdy[0] ? up_valid     : valid_reg[0];
        valid_next[1] = rdy[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = rdy[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = rdy[3] ? valid_reg[2] : valid_reg[3];
        valid_next[4] = rdy[4] ? valid_reg[3] : valid_reg[4];
    end

    // Stage 2: quotient by 60, or days times 24 plus hour
    always_comb
    begin
        logic [63:0] prod;
        prod    = {32'd0, up_data.acc} * {32'd0, RECIP_60};
        s2_next = up_data;
        if (up_data.req == REQ_TO_DATE)
        begin
            s2_next.quo = 32'(prod[63:SHIFT_60]);
        end
        else
        begin
            s2_next.acc = up_data.acc * 32'd24 + {27'd0, up_data.hr};
        end
    end

    // Stage 3: seconds remainder and quotient by 60 again, or times 60 plus minute
    always_comb
    begin
        logic [63:0] prod;
        logic [31:0] rem;
        prod    = {32'd0, s2_reg.quo} * {32'd0, RECIP_60};
        rem     = s2_reg.acc - s2_reg.quo * 32'd60;
        s3_next = s2_reg;
        if (s2_reg.req == REQ_TO_DATE)
        begin
            s3_next.se  = rem[5:0];
            s3_next.acc = s2_reg.quo;
            s3_next.quo = 32'(prod[63:SHIFT_60]);
        end
        else
        begin
            s3_next.acc = s2_reg.acc * 32'd60 + {26'd0, s2_reg.mi};
        end
    end

    // Stage 4: minutes remainder and quotient by 24, or times 60 plus second
    always_comb
    begin
        logic [40:0] prod;
        logic [31:0] rem;
        prod    = {21'd0, s3_reg.quo[19:0]} * {20'd0, RECIP_24};
        rem     = s3_reg.acc - s3_reg.quo * 32'd60;
        s4_next = s3_reg;
        if (s3_reg.req == REQ_TO_DATE)
        begin
            s4_next.mi  = rem[5:0];
            s4_next.acc = s3_reg.quo;
            s4_next.quo = 32'(prod[40:SHIFT_24]);
        end
        else
        begin
            s4_next.acc = s3_reg.acc * 32'd60 + {26'd0, s3_reg.se};
        end
    end

    // Stage 5: hours remainder and quotient by cycle length, or add the 2000 offset
    always_comb
    begin
        logic [37:0] prod;
        logic [31:0] rem;
        prod    = {22'd0, s4_reg.quo[15:0]} * {16'd0, RECIP_1461};
        rem     = s4_reg.acc - s4_reg.quo * 32'd24;
        s5_next = s4_reg;
        if (s4_reg.req == REQ_TO_DATE)
        begin
            s5_next.hr  = rem[4:0];
            s5_next.acc = s4_reg.quo;
            s5_next.quo = 32'(prod[37:SHIFT_1461]);
        end
        else
        begin
            s5_next.acc = s4_reg.acc + EPOCH_Y2K;
        end
    end

    // Stage 6: day within the cycle and first year of the cycle
    always_comb
    begin
        s6_next = s5_reg;
        if (s5_reg.req == REQ_TO_DATE)
        begin
            s6_next.acc = s5_reg.acc - s5_reg.quo * {21'd0, CYCLE_DAYS};
            s6_next.quo = {s5_reg.quo[29:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance payload where the stage loads
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s2_reg <= s2_next;
        end
        if (rdy[1])
        begin
            s3_reg <= s3_next;
        end
        if (rdy[2])
        begin
            s4_reg <= s4_next;
        end
        if (rdy[3])
        begin
            s5_reg <= s5_next;
        end
        if (rdy[4])
        begin
            s6_reg <= s6_next;
        end
    end

    assign up_ready   = rdy[0];
    assign down_valid = valid_reg[4];
    assign down_data  = s6_reg;

endmodule

`default_nettype wire

/* design/ecc_calendar.sv */
// Last stage: year and month lookup in the cycle table and the output register.
`default_nettype none

module ecc_calendar (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire ecc_pkg::ecc_stage_t up_data,
    output logic                     down_valid,
    input  wire logic                down_ready,
    output ecc_pkg::ecc_out_t        down_data
);
    import ecc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ecc_out_t res_reg;
    ecc_out_t res_next;

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // Resolve year in cycle, month and day, then shape the result beat
    always_comb
    begin
        logic [10:0] eday;
        logic [1:0]  yin;
        logic [3:0]  mon;
        logic [10:0] dofs;

        eday = up_data.acc[10:0];

        if (eday >= MONTH_START[3][0])
        begin
            yin = 2'd3;
        end
        else if (eday >= MONTH_START[2][0])
        begin
            yin = 2'd2;
        end
        else if (eday >= MONTH_START[1][0])
        begin
            yin = 2'd1;
        end
        else
        begin
            yin = 2'd0;
        end

        // Offsets rise along a row, so the last month start passed wins
        mon = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (eday >= MONTH_START[yin][k])
            begin
                mon = 4'(k);
            end
        end

        dofs = eday - MONTH_START[yin][mon] + 11'd1;

        res_next = '0;
        if (up_data.err)
        begin
            res_next.range_error = 1'b1;
        end
        else if (up_data.req == REQ_TO_EPOCH)
        begin
            res_next.epoch_out = up_data.acc;
        end
        else
        begin
            res_next.year_out   = up_data.quo[6:0] + {5'd0, yin};
            res_next.month_out  = mon + 4'd1;
            res_next.day_out    = dofs[4:0];
            res_next.hour_out   = up_data.hr;
            res_next.minute_out = up_data.mi;
            res_next.second_out = up_data.se;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = res_reg;

endmodule

`default_nettype wire

/* design/epoch_calendar_converter.sv */
// Top level of the epoch calendar converter: front stage, arithmetic stages, calendar stage.
// Converts between Unix epoch seconds and a date and time in 2000..2099 in either direction,
// selected per beat by req_type. The block is a seven-stage pipeline that, while rsp is not
// stalled, accepts a new beat every cycle. The seven register stages (range check and day
// count, four reciprocal divisions by 60, 60, 24 and 1461, cycle remainder, table lookup with
// output register) set the latency. Each stage holds its beat only while its successor is full
// and stalled, so a stalled rsp fills the empty stages before cmd_ready drops. Out-of-range
// epochs return range_error with all other fields zero; the unused direction's fields are zero.
`default_nettype none

module epoch_calendar_converter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire ecc_pkg::ecc_in_t cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output ecc_pkg::ecc_out_t     rsp
);
    import ecc_pkg::*;

    logic       front_valid;
    logic       front_ready;
    ecc_stage_t front_data;
    logic       arith_valid;
    logic       arith_ready;
    ecc_stage_t arith_data;

    ecc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (cmd_valid),
        .up_ready   (cmd_ready),
        .up_data    (cmd),
        .down_valid (front_valid),
        .down_ready (front_ready),
        .down_data  (front_data)
    );

    ecc_arith u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (front_valid),
        .up_ready   (front_ready),
        .up_data    (front_data),
        .down_valid (arith_valid),
        .down_ready (arith_ready),
        .down_data  (arith_data)
    );

    ecc_calendar u_calendar (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (arith_valid),
        .up_ready   (arith_ready),
        .up_data    (arith_data),
        .down_valid (rsp_valid),
        .down_ready (rsp_ready),
        .down_data  (rsp)
    );

    // Back-pressure reaches cmd only through a stalled result
    a_stall_from_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (rsp_valid && !rsp_ready))
        else $error("cmd stalled while rsp free");

    // A range error carries no date or epoch
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.range_error) |->
            (rsp.epoch_out == 32'd0 && rsp.month_out == 4'd0 && rsp.day_out == 5'd0
             && rsp.year_out == 7'd0))
        else $error("range error beat has non-zero fields");

    // A decoded date has a real month and day and no epoch
    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.month_out != 4'd0) |->
            (rsp.month_out <= 4'd12 && rsp.day_out != 5'd0 && rsp.epoch_out == 32'd0
             && rsp.year_out <= 7'd99 && rsp.hour_out <= 5'd23 && !rsp.range_error))
        else $error("decoded date out of range");

endmodule

`default_nettype wire
